// ===== rtl/alb_pkg.sv =====
// Shared types, constants and lookup functions for the ARP load-balance responder.
// Used by alb_cfg_regs, the top level and the testbench; depends on nothing.
package alb_pkg;

  localparam int FRAME_BYTES_DEF = 42;
  localparam int ARP_LEN         = 42;
  localparam int IDX_W           = 6;
  localparam int CHK_W           = 4;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = 48;
  localparam int NUM_VIP         = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIP_VALID = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIP_0     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIP_1     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VIP_2     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VIP_3     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAC_EVEN  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAC_ODD   = 4'd7;

  localparam logic [IDX_W-1:0] LAST_IDX = 6'd41;
  localparam logic [CHK_W-1:0] CHK_LAST = 4'd15;

  typedef struct packed {
    logic                     enable;
    logic [NUM_VIP-1:0]       vip_valid;
    logic [NUM_VIP-1:0][31:0] vip;
    logic [47:0]              mac_even;
    logic [47:0]              mac_odd;
  } cfg_t;

  typedef enum logic [1:0] {
    SRC_MEM   = 2'd0,
    SRC_MAC   = 2'd1,
    SRC_CONST = 2'd2
  } src_kind_t;

  typedef struct packed {
    src_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [7:0]       value;
  } src_t;

  // Where reply byte k comes from: a stored request byte, a MAC byte or a constant.
  function automatic src_t reply_src(input logic [IDX_W-1:0] k);
    src_t s;
    s.kind  = SRC_MEM;
    s.idx   = k;
    s.value = 8'h00;
    if (k < 6'd6) begin
      s.idx = k + 6'd22;
    end else if (k < 6'd12) begin
      s.kind = SRC_MAC;
      s.idx  = k - 6'd6;
    end else if (k < 6'd20) begin
      s.idx = k;
    end else if (k == 6'd20) begin
      s.kind  = SRC_CONST;
      s.value = 8'h00;
    end else if (k == 6'd21) begin
      s.kind  = SRC_CONST;
      s.value = 8'h02;
    end else if (k < 6'd28) begin
      s.kind = SRC_MAC;
      s.idx  = k - 6'd22;
    end else if (k < 6'd32) begin
      s.idx = k + 6'd10;
    end else begin
      s.idx = k - 6'd10;
    end
    return s;
  endfunction

  // Read order of the header check: eight fixed bytes, then sender IP, then target IP.
  function automatic logic [IDX_W-1:0] chk_addr(input logic [CHK_W-1:0] step);
    logic [IDX_W-1:0] a;
    case (step)
      4'd0:    a = 6'd12;
      4'd1:    a = 6'd13;
      4'd2:    a = 6'd16;
      4'd3:    a = 6'd17;
      4'd4:    a = 6'd18;
      4'd5:    a = 6'd19;
      4'd6:    a = 6'd20;
      4'd7:    a = 6'd21;
      4'd8:    a = 6'd28;
      4'd9:    a = 6'd29;
      4'd10:   a = 6'd30;
      4'd11:   a = 6'd31;
      4'd12:   a = 6'd38;
      4'd13:   a = 6'd39;
      4'd14:   a = 6'd40;
      default: a = 6'd41;
    endcase
    return a;
  endfunction

  // Expected values: ethertype ARP, protocol IPv4, lengths 6 and 4, opcode request.
  function automatic logic [7:0] chk_expect(input logic [2:0] step);
    logic [7:0] v;
    case (step)
      3'd0:    v = 8'h08;
      3'd1:    v = 8'h06;
      3'd2:    v = 8'h08;
      3'd3:    v = 8'h00;
      3'd4:    v = 8'h06;
      3'd5:    v = 8'h04;
      3'd6:    v = 8'h00;
      default: v = 8'h01;
    endcase
    return v;
  endfunction

  // Byte j of a MAC address, first wire byte most significant.
  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [IDX_W-1:0] j);
    logic [7:0] b;
    case (j)
      6'd0:    b = mac[47:40];
      6'd1:    b = mac[39:32];
      6'd2:    b = mac[31:24];
      6'd3:    b = mac[23:16];
      6'd4:    b = mac[15:8];
      default: b = mac[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/alb_cfg_regs.sv =====
// Configuration register file of the ARP load-balance responder.
// Depends on alb_pkg for the register indexes and the cfg_t struct.
module alb_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [alb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [alb_pkg::CFG_DATA_W-1:0]   cfg_data,
  output alb_pkg::cfg_t                    cfg
);

  alb_pkg::cfg_t cfg_r;
  alb_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        alb_pkg::REG_ENABLE:    cfg_nxt.enable    = cfg_data[0];
        alb_pkg::REG_VIP_VALID: cfg_nxt.vip_valid = cfg_data[3:0];
        alb_pkg::REG_VIP_0:     cfg_nxt.vip[0]    = cfg_data[31:0];
        alb_pkg::REG_VIP_1:     cfg_nxt.vip[1]    = cfg_data[31:0];
        alb_pkg::REG_VIP_2:     cfg_nxt.vip[2]    = cfg_data[31:0];
        alb_pkg::REG_VIP_3:     cfg_nxt.vip[3]    = cfg_data[31:0];
        alb_pkg::REG_MAC_EVEN:  cfg_nxt.mac_even  = cfg_data[47:0];
        alb_pkg::REG_MAC_ODD:   cfg_nxt.mac_odd   = cfg_data[47:0];
        default:                cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/alb_frame_mem.sv =====
// Frame store: one write port and one read port with registered read data.
// Depends on nothing beyond its parameters.
module alb_frame_mem #(
  parameter int DEPTH = 42,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

// ===== rtl/arp_load_balance_responder.sv =====
// Top level of the ARP load-balance responder: frame intake, check and reply sequencer.
// Depends on alb_pkg, alb_cfg_regs and alb_frame_mem.
//
//   Port group   Direction  Handshake             Word
//   in_*         in         in_valid / in_stall   one frame byte with last and outgoing flags
//   out_*        out        out_valid / out_stall one reply byte with neighbor report
//   cfg_*        in         cfg_valid / cfg_ready register index and write data
//
// Frame bytes are taken one per cycle while the sequencer is idle.
// A frame that qualifies passes header reads (ST_CHECK, ST_TAIL), up to 4 address
// compares (ST_MATCH), then ST_READ and ST_PUT per byte over the single store read port.
// Reset is synchronous and active low; it clears counters, state, out_valid and config.
// A stalled output holds its word; the sequencer waits for the output register to free.
module arp_load_balance_responder #(
  parameter int FRAME_BYTES = alb_pkg::FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_frame_byte,
  input  logic                           in_last_byte,
  input  logic                           in_outgoing,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_reply_byte,
  output logic                           out_reply_last,
  output logic [31:0]                    out_neighbor_ip,
  output logic                           out_neighbor_odd,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [alb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alb_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_TAIL  = 6'b000100,
    ST_MATCH = 6'b001000,
    ST_READ  = 6'b010000,
    ST_PUT   = 6'b100000
  } state_t;

  alb_pkg::cfg_t cfg;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [alb_pkg::CHK_W-1:0]  step_r, step_nxt;
  logic [alb_pkg::CHK_W-1:0]  tag_r;
  logic                       tag_live_r;
  logic                       bad_r;
  logic [31:0]                sip_r;
  logic [31:0]                tip_r;
  logic [1:0]                 slot_r, slot_nxt;
  logic [alb_pkg::IDX_W-1:0]  k_r, k_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_byte_r;
  logic                       out_last_r;
  logic [31:0]                out_ip_r;
  logic                       out_odd_r;

  logic                       in_take;
  logic                       mem_wr_en;
  logic [AW-1:0]              mem_rd_addr;
  logic [7:0]                 mem_rd_data;
  logic                       long_enough;
  logic                       vip_hit;
  logic                       out_free;
  logic                       load_out;
  logic                       is_last;
  logic [47:0]                chosen_mac;
  logic [7:0]                 reply_byte;
  alb_pkg::src_t              src;

  alb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  alb_frame_mem #(
    .DEPTH (FRAME_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_frame_byte),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign in_stall    = (state_r != ST_IDLE);
  assign in_take     = in_valid && !in_stall;
  assign mem_wr_en   = in_take && (count_r < CW'(FRAME_BYTES));
  assign long_enough = (count_r >= CW'(alb_pkg::ARP_LEN - 1));

  assign src        = alb_pkg::reply_src(k_r);
  assign chosen_mac = sip_r[0] ? cfg.mac_odd : cfg.mac_even;
  assign is_last    = (k_r == alb_pkg::LAST_IDX);
  assign vip_hit    = cfg.vip_valid[slot_r] && (cfg.vip[slot_r] == tip_r);
  assign out_free   = !out_valid_r || !out_stall;
  assign load_out   = (state_r == ST_PUT) && out_free;

  always_comb begin
    if (state_r == ST_CHECK) begin
      mem_rd_addr = AW'(alb_pkg::chk_addr(step_r));
    end else begin
      mem_rd_addr = AW'(src.idx);
    end
  end

  always_comb begin
    case (src.kind)
      alb_pkg::SRC_MEM:   reply_byte = mem_rd_data;
      alb_pkg::SRC_MAC:   reply_byte = alb_pkg::mac_byte(chosen_mac, src.idx);
      alb_pkg::SRC_CONST: reply_byte = src.value;
      default:            reply_byte = src.value;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    step_nxt  = step_r;
    slot_nxt  = slot_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_last_byte) begin
            count_nxt = '0;
            if (cfg.enable && !in_outgoing && long_enough) begin
              state_nxt = ST_CHECK;
              step_nxt  = '0;
            end
          end else if (count_r < CW'(FRAME_BYTES)) begin
            count_nxt = count_r + CW'(1);
          end
        end
      end
      ST_CHECK: begin
        step_nxt = step_r + alb_pkg::CHK_W'(1);
        if (step_r == alb_pkg::CHK_LAST) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_MATCH;
        slot_nxt  = '0;
      end
      ST_MATCH: begin
        if (bad_r) begin
          state_nxt = ST_IDLE;
        end else if (vip_hit) begin
          state_nxt = ST_READ;
          k_nxt     = '0;
        end else if (slot_r == 2'd3) begin
          state_nxt = ST_IDLE;
        end else begin
          slot_nxt = slot_r + 2'd1;
        end
      end
      ST_READ: begin
        state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (out_free) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + alb_pkg::IDX_W'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      slot_r      <= '0;
      k_r         <= '0;
      tag_live_r  <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      slot_r      <= slot_nxt;
      k_r         <= k_nxt;
      tag_live_r  <= (state_r == ST_CHECK);
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_IDLE) begin
        bad_r <= 1'b0;
      end else if (tag_live_r && !tag_r[3]) begin
        if (mem_rd_data != alb_pkg::chk_expect(tag_r[2:0])) begin
          bad_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= step_r;
    if (tag_live_r && tag_r[3]) begin
      if (tag_r[2]) begin
        tip_r <= {tip_r[23:0], mem_rd_data};
      end else begin
        sip_r <= {sip_r[23:0], mem_rd_data};
      end
    end
    if (load_out) begin
      out_byte_r <= reply_byte;
      out_last_r <= is_last;
      out_ip_r   <= is_last ? sip_r : 32'd0;
      out_odd_r  <= is_last && sip_r[0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_reply_byte   = out_byte_r;
  assign out_reply_last   = out_last_r;
  assign out_neighbor_ip  = out_ip_r;
  assign out_neighbor_odd = out_odd_r;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for arp_load_balance_responder: frame words go in through a
// queue-fed driver, reply words are checked against an in-bench ARP responder model.
// Depends on alb_pkg and the RTL of the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES   = alb_pkg::FRAME_BYTES_DEF;
  localparam int ARP_LEN       = alb_pkg::ARP_LEN;
  localparam int NUM_VIP       = alb_pkg::NUM_VIP;
  localparam int CFG_IDX_W     = alb_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W    = alb_pkg::CFG_DATA_W;
  localparam int MAX_FRAME     = 80;
  localparam int SETTLE_CYCLES = 160;
  localparam int LONG_HOLD     = 600;
  localparam int ITEM_BUDGET   = 360;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam logic [15:0] ARP_ETHTYPE = 16'h0806;
  localparam logic [15:0] HTYPE_ETH   = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  HLEN_ETH    = 8'd6;
  localparam logic [7:0]  PLEN_IPV4   = 8'd4;
  localparam logic [15:0] OP_REQUEST  = 16'h0001;
  localparam logic [15:0] OP_REPLY    = 16'h0002;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       outgoing;
  } frame_word_t;

  typedef struct packed {
    logic [7:0]  reply_byte;
    logic        reply_last;
    logic [31:0] neighbor_ip;
    logic        neighbor_odd;
  } reply_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_frame_byte = '0;
  logic                  in_last_byte = 1'b0;
  logic                  in_outgoing = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_reply_byte;
  logic                  out_reply_last;
  logic [31:0]           out_neighbor_ip;
  logic                  out_neighbor_odd;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_word_t frame_word_q[$];
  reply_word_t reply_q[$];

  bit drv_busy = 1'b0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit long_hold_arm = 1'b0;
  bit long_hold_done = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;
  int errors = 0;
  int cycle_count = 0;
  int sent_bytes = 0;

  logic                     sh_enable = 1'b0;
  logic [NUM_VIP-1:0]       sh_vip_valid = '0;
  logic [NUM_VIP-1:0][31:0] sh_vip = '0;
  logic [47:0]              sh_mac_even = '0;
  logic [47:0]              sh_mac_odd = '0;
  int                       sh_count = 0;
  logic [7:0]               sh_frame [0:FRAME_BYTES-1];

  logic [7:0] frm [0:MAX_FRAME-1];
  int         frm_len = 0;

  arp_load_balance_responder #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_byte    (in_frame_byte),
    .in_last_byte     (in_last_byte),
    .in_outgoing      (in_outgoing),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reply_byte   (out_reply_byte),
    .out_reply_last   (out_reply_last),
    .out_neighbor_ip  (out_neighbor_ip),
    .out_neighbor_odd (out_neighbor_odd),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int draw_gap(input bit quiet);
    if (quiet || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic logic [47:0] rnd48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // Stores one frame word and, on the last word of a qualifying request, queues the reply.
  task automatic arp_model_byte(input frame_word_t w);
    logic [7:0]  rep [0:ARP_LEN-1];
    logic [47:0] mac;
    logic [31:0] sip;
    logic [31:0] tip;
    logic        hit;
    logic        odd;
    reply_word_t r;
    if (sh_count < FRAME_BYTES) begin
      sh_frame[sh_count] = w.data;
      sh_count++;
    end
    if (w.last) begin
      hit = 1'b0;
      if (sh_enable && !w.outgoing && sh_count >= ARP_LEN) begin
        tip = {sh_frame[38], sh_frame[39], sh_frame[40], sh_frame[41]};
        if ({sh_frame[12], sh_frame[13]} == ARP_ETHTYPE &&
            {sh_frame[16], sh_frame[17]} == PTYPE_IPV4 &&
            sh_frame[18] == HLEN_ETH && sh_frame[19] == PLEN_IPV4 &&
            {sh_frame[20], sh_frame[21]} == OP_REQUEST) begin
          for (int i = 0; i < NUM_VIP; i++) begin
            if (sh_vip_valid[i] && sh_vip[i] == tip) begin
              hit = 1'b1;
            end
          end
        end
      end
      sh_count = 0;
      if (hit) begin
        sip = {sh_frame[28], sh_frame[29], sh_frame[30], sh_frame[31]};
        odd = sip[0];
        mac = odd ? sh_mac_odd : sh_mac_even;
        for (int k = 0; k < ARP_LEN; k++) begin
          rep[k] = sh_frame[k];
        end
        for (int k = 0; k < 6; k++) begin
          rep[k]      = sh_frame[22 + k];
          rep[6 + k]  = mac[47 - 8 * k -: 8];
          rep[22 + k] = mac[47 - 8 * k -: 8];
          rep[32 + k] = sh_frame[22 + k];
        end
        rep[20] = OP_REPLY[15:8];
        rep[21] = OP_REPLY[7:0];
        for (int k = 0; k < 4; k++) begin
          rep[28 + k] = sh_frame[38 + k];
          rep[38 + k] = sh_frame[28 + k];
        end
        for (int k = 0; k < ARP_LEN; k++) begin
          r.reply_byte   = rep[k];
          r.reply_last   = (k == ARP_LEN - 1);
          r.neighbor_ip  = r.reply_last ? sip : 32'd0;
          r.neighbor_odd = r.reply_last ? odd : 1'b0;
          reply_q.push_back(r);
        end
      end
    end
  endtask

  always @(posedge clk) begin : drive
    logic        take;
    logic        nv;
    frame_word_t got;
    frame_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_busy = 1'b0;
      tx_gap = 0;
    end else begin
      take = in_valid && !in_stall;
      if (take) begin
        got.data     = in_frame_byte;
        got.last     = in_last_byte;
        got.outgoing = in_outgoing;
        arp_model_byte(got);
        tx_gap = draw_gap(tx_quiet);
      end
      nv = in_valid && !take;
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (frame_word_q.size() != 0) begin
          w = frame_word_q.pop_front();
          in_frame_byte <= w.data;
          in_last_byte  <= w.last;
          in_outgoing   <= w.outgoing;
          nv = 1'b1;
        end
      end
      drv_busy = nv;
      in_valid <= nv;
    end
  end

  always @(posedge clk) begin : monitor
    reply_word_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $error("unexpected reply word: reply_byte %h", out_reply_byte);
          errors++;
        end else begin
          exp_r = reply_q.pop_front();
          if (out_reply_byte !== exp_r.reply_byte) begin
            $error("reply_byte expected %h got %h", exp_r.reply_byte, out_reply_byte);
            errors++;
          end
          if (out_reply_last !== exp_r.reply_last) begin
            $error("reply_last expected %h got %h", exp_r.reply_last, out_reply_last);
            errors++;
          end
          if (out_neighbor_ip !== exp_r.neighbor_ip) begin
            $error("neighbor_ip expected %h got %h", exp_r.neighbor_ip, out_neighbor_ip);
            errors++;
          end
          if (out_neighbor_odd !== exp_r.neighbor_odd) begin
            $error("neighbor_odd expected %h got %h", exp_r.neighbor_odd, out_neighbor_odd);
            errors++;
          end
        end
        rx_gap = draw_gap(rx_quiet);
      end
      if (long_hold_arm && !long_hold_done) begin
        rx_gap = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (rx_gap > 0) begin
        out_stall <= 1'b1;
        rx_gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[arp_load_balance_responder] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      alb_pkg::REG_ENABLE:    sh_enable = val[0];
      alb_pkg::REG_VIP_VALID: sh_vip_valid = val[NUM_VIP-1:0];
      alb_pkg::REG_VIP_0:     sh_vip[0] = val[31:0];
      alb_pkg::REG_VIP_1:     sh_vip[1] = val[31:0];
      alb_pkg::REG_VIP_2:     sh_vip[2] = val[31:0];
      alb_pkg::REG_VIP_3:     sh_vip[3] = val[31:0];
      alb_pkg::REG_MAC_EVEN:  sh_mac_even = val[47:0];
      alb_pkg::REG_MAC_ODD:   sh_mac_odd = val[47:0];
      default: ;
    endcase
  endtask

  // Unused upper data bits carry noise; a write to an unmapped index is mixed in.
  task automatic apply_config(input logic en, input logic [NUM_VIP-1:0] vv,
                              input logic [NUM_VIP-1:0][31:0] vips,
                              input logic [47:0] me, input logic [47:0] mo);
    logic [CFG_DATA_W-1:0] v;
    v = rnd48();
    v[0] = en;
    write_reg(alb_pkg::REG_ENABLE, v);
    v = rnd48();
    v[NUM_VIP-1:0] = vv;
    write_reg(alb_pkg::REG_VIP_VALID, v);
    for (int i = 0; i < NUM_VIP; i++) begin
      v = rnd48();
      v[31:0] = vips[i];
      write_reg(CFG_IDX_W'(alb_pkg::REG_VIP_0 + i), v);
    end
    write_reg(CFG_IDX_W'($urandom_range(alb_pkg::REG_MAC_ODD + 1, (1 << CFG_IDX_W) - 1)),
              rnd48());
    write_reg(alb_pkg::REG_MAC_EVEN, me);
    write_reg(alb_pkg::REG_MAC_ODD, mo);
    cfg_valid <= 1'b0;
  endtask

  task automatic build_request(input logic [47:0] sha, input logic [31:0] sip,
                               input logic [31:0] tip, input int pad);
    logic [47:0] tha;
    tha = rnd48();
    for (int k = 0; k < 6; k++) begin
      frm[k]      = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom);
      frm[6 + k]  = sha[47 - 8 * k -: 8];
      frm[22 + k] = sha[47 - 8 * k -: 8];
      frm[32 + k] = tha[47 - 8 * k -: 8];
    end
    {frm[12], frm[13]} = ARP_ETHTYPE;
    {frm[14], frm[15]} = HTYPE_ETH;
    {frm[16], frm[17]} = PTYPE_IPV4;
    frm[18] = HLEN_ETH;
    frm[19] = PLEN_IPV4;
    {frm[20], frm[21]} = OP_REQUEST;
    {frm[28], frm[29], frm[30], frm[31]} = sip;
    {frm[38], frm[39], frm[40], frm[41]} = tip;
    for (int k = ARP_LEN; k < ARP_LEN + pad; k++) begin
      frm[k] = 8'($urandom);
    end
    frm_len = ARP_LEN + pad;
  endtask

  // The outgoing flag only matters on the last word, so it is noise elsewhere.
  task automatic send_frame(input logic og);
    frame_word_t w;
    for (int i = 0; i < frm_len; i++) begin
      w.data     = frm[i];
      w.last     = (i == frm_len - 1);
      w.outgoing = w.last ? og : 1'($urandom_range(0, 1));
      frame_word_q.push_back(w);
    end
    sent_bytes += frm_len;
  endtask

  task automatic wait_replies();
    while (frame_word_q.size() != 0 || drv_busy || reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_frame(input bit request_only, output logic og);
    int          kind;
    int          s;
    int          c;
    int          pad;
    logic [31:0] tip;
    kind = request_only ? 0 : $urandom_range(0, 9);
    tip = $urandom;
    if (sh_vip_valid != '0 && (request_only || $urandom_range(0, 4) != 0)) begin
      do s = $urandom_range(0, NUM_VIP - 1); while (!sh_vip_valid[s]);
      tip = sh_vip[s];
    end
    pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 22) : 0;
    build_request(rnd48(), $urandom, tip, pad);
    if ($urandom_range(0, 3) == 0) begin
      frm[14] = 8'($urandom);
      frm[15] = 8'($urandom);
    end
    if (kind == 7) begin
      c = $urandom_range(0, 7);
      c = (c < 2) ? 12 + c : 14 + c;
      frm[c] = frm[c] ^ (8'h01 << $urandom_range(0, 7));
    end else if (kind == 8) begin
      frm_len = $urandom_range(1, ARP_LEN - 1);
    end else if (kind == 9) begin
      frm_len = $urandom_range(1, 64);
      for (int k = 0; k < frm_len; k++) begin
        frm[k] = 8'($urandom);
      end
    end
    og = request_only ? 1'b0 : ($urandom_range(0, 9) == 0);
  endtask

  function automatic logic [31:0] pick_ip();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [47:0] pick_mac();
    case ($urandom_range(0, 5))
      0:       return 48'h0000_0000_0000;
      1:       return 48'hFFFF_FFFF_FFFF;
      default: return rnd48();
    endcase
  endfunction

  initial begin : stimulus
    logic [NUM_VIP-1:0][31:0] vips;
    logic                     og;
    int                       phase;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      sh_frame[k] = 8'h00;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    vips[0] = 32'h0A00_0001;
    vips[1] = 32'hFFFF_FFFF;
    vips[2] = 32'h0000_0000;
    vips[3] = 32'hC0A8_0164;
    apply_config(1'b1, 4'hF, vips, 48'h0000_5E00_0101, 48'hFFFF_FFFF_FFFF);

    build_request(rnd48(), 32'h0A00_0002, vips[0], 0);
    send_frame(1'b0);
    build_request(rnd48(), 32'h0A00_0003, vips[0], 0);
    send_frame(1'b0);
    wait_replies();
    build_request(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, vips[1], 22);
    send_frame(1'b0);
    build_request(rnd48(), $urandom, vips[0], 0);
    frm_len = ARP_LEN - 1;
    send_frame(1'b0);
    frm_len = 1;
    send_frame(1'b0);
    build_request(rnd48(), $urandom, vips[1], 0);
    send_frame(1'b1);
    drain();

    phase = 0;
    while (sent_bytes < ITEM_BUDGET) begin
      for (int i = 0; i < NUM_VIP; i++) begin
        vips[i] = pick_ip();
      end
      if (phase == 0) begin
        apply_config(1'b1, 4'hF, vips, pick_mac(), pick_mac());
        tx_quiet = 1'b1;
        rx_quiet = 1'b0;
        long_hold_arm = 1'b1;
      end else begin
        apply_config($urandom_range(0, 7) != 0,
                     ($urandom_range(0, 2) == 0) ? 4'hF : NUM_VIP'($urandom_range(0, 15)),
                     vips, pick_mac(), pick_mac());
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      repeat ($urandom_range(2, 3)) begin
        random_frame(phase == 0, og);
        send_frame(og);
        if (phase != 0 && $urandom_range(0, 3) == 0) begin
          wait_replies();
        end
      end
      drain();
      phase++;
    end

    if (errors == 0) begin
      $display("[arp_load_balance_responder] OK");
    end else begin
      $display("[arp_load_balance_responder] ERROR");
    end
    $finish;
  end

endmodule
